@@ hdl/mms_pkg.sv @@
// Shared constants and control types for the min/max stack.
`default_nettype none
package mms_pkg;

  // Capacity of the stack in entries.
  localparam int STACK_DEPTH = 64;

  // Width of a RAM address and of the entry counter, which must also hold the full count.
  localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);

  // Field widths of the request and result.
  localparam int WORD_W  = 32;
  localparam int DEPTH_W = 7;
  localparam int STS_W   = 2;

  // One stored entry holds the value and the min and max down to the bottom.
  localparam int ENTRY_W = 3 * WORD_W;

  // Packed widths of the stream data buses, rounded up to whole bytes.
  localparam int IN_DATA_W  = ((WORD_W + 7) / 8) * 8;
  localparam int OUT_BITS   = 3 * WORD_W + DEPTH_W + 1 + STS_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Status codes.
  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             do_push;
    logic             do_pop;
    logic             do_load_top;
    logic             load_out;
    logic [STS_W-1:0] status;
  } mms_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic one_left;
  } mms_sts_t;

endpackage
`default_nettype wire

@@ hdl/mms_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/mms_ctrl.sv @@
// Controller state machine: request handshake, result valid and datapath commands.
`default_nettype none
module mms_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              in_op,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire mms_pkg::mms_sts_t sts,
  output mms_pkg::mms_cmd_t      cmd
);
  import mms_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOAD = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  // A new request is taken when idle and the result register is free or draining.
  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Command decode and next state.
  always_comb begin
    cmd       = '0;
    cmd.status = ST_OK;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_PUSH) begin
            if (sts.full) begin
              cmd.status = ST_FULL;
            end else begin
              cmd.do_push = 1'b1;
            end
            cmd.load_out = 1'b1;
          end else begin
            if (sts.empty) begin
              cmd.status   = ST_EMPTY;
              cmd.load_out = 1'b1;
            end else begin
              cmd.do_pop = 1'b1;
              // The new top comes from the RAM unless the stack goes empty.
              if (sts.one_left) begin
                cmd.load_out = 1'b1;
              end else begin
                state_nxt = S_LOAD;
              end
            end
          end
        end
      end
      S_LOAD: begin
        cmd.do_load_top = 1'b1;
        cmd.load_out    = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result valid holds until the result is taken.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/mms_dp.sv @@
// Datapath: entry counter, cached top entry, entry RAM and result registers.
`default_nettype none
module mms_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic signed [mms_pkg::WORD_W-1:0]   push_value,
  input  wire mms_pkg::mms_cmd_t                   cmd,
  output mms_pkg::mms_sts_t                        sts,
  output logic signed [mms_pkg::WORD_W-1:0]        popped_value,
  output logic signed [mms_pkg::WORD_W-1:0]        current_min,
  output logic signed [mms_pkg::WORD_W-1:0]        current_max,
  output logic        [mms_pkg::DEPTH_W-1:0]       depth_now,
  output logic                                     is_empty,
  output logic        [mms_pkg::STS_W-1:0]         status
);
  import mms_pkg::*;

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [WORD_W-1:0] top_val_r, top_val_nxt;
  logic signed [WORD_W-1:0] top_min_r, top_min_nxt;
  logic signed [WORD_W-1:0] top_max_r, top_max_nxt;
  logic signed [WORD_W-1:0] pop_hold_r;
  logic signed [WORD_W-1:0] new_min, new_max, res_pop;
  logic [ENTRY_W-1:0]       ram_wdata, ram_rdata;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;

  assign sts.full     = (count_r == CNT_W'(STACK_DEPTH));
  assign sts.empty    = (count_r == '0);
  assign sts.one_left = (count_r == CNT_W'(1));

  // Min and max of the pushed value and everything below it.
  always_comb begin
    new_min = push_value;
    new_max = push_value;
    if (!sts.empty) begin
      if (top_min_r < push_value) begin
        new_min = top_min_r;
      end
      if (top_max_r > push_value) begin
        new_max = top_max_r;
      end
    end
  end

  // The entry is stored at the current count; a pop reads the entry under the top.
  assign ram_waddr = count_r[ADDR_W-1:0];
  assign ram_wdata = {new_max, new_min, push_value};
  assign ram_raddr = ADDR_W'(count_r - CNT_W'(2));

  mms_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.do_push),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next counter and cached top entry.
  always_comb begin
    count_nxt   = count_r;
    top_val_nxt = top_val_r;
    top_min_nxt = top_min_r;
    top_max_nxt = top_max_r;
    if (cmd.do_push) begin
      count_nxt   = count_r + CNT_W'(1);
      top_val_nxt = push_value;
      top_min_nxt = new_min;
      top_max_nxt = new_max;
    end else if (cmd.do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (cmd.do_load_top) begin
      top_val_nxt = ram_rdata[WORD_W-1:0];
      top_min_nxt = ram_rdata[2*WORD_W-1:WORD_W];
      top_max_nxt = ram_rdata[3*WORD_W-1:2*WORD_W];
    end
  end

  // Popped value: the top itself, or the one held while the new top is read.
  always_comb begin
    res_pop = '0;
    if (cmd.do_pop) begin
      res_pop = top_val_r;
    end else if (cmd.do_load_top) begin
      res_pop = pop_hold_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Top entry and pop hold register.
  always_ff @(posedge clk) begin
    top_val_r <= top_val_nxt;
    top_min_r <= top_min_nxt;
    top_max_r <= top_max_nxt;
    if (cmd.do_pop) begin
      pop_hold_r <= top_val_r;
    end
  end

  // Result register; min and max read as zero on an empty stack.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      popped_value <= res_pop;
      current_min  <= (count_nxt == '0) ? '0 : top_min_nxt;
      current_max  <= (count_nxt == '0) ? '0 : top_max_nxt;
      depth_now    <= DEPTH_W'(count_nxt);
      is_empty     <= (count_nxt == '0);
      status       <= cmd.status;
    end
  end

endmodule
`default_nettype wire

@@ hdl/min_max_stack.sv @@
// Min/max stack: an integer stack that reports running minimum and maximum.
// A push, a dropped push and a pop on empty give their result in the cycle after the
// request; a pop that leaves entries gives it after the load state, set by the registered RAM read.
// One request per cycle for those while the result side keeps up; such a pop holds off new ones.
// Reset: synchronous, active low; it empties the stack, no RAM clearing pass is needed.
`default_nettype none
module min_max_stack (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [mms_pkg::IN_DATA_W-1:0]     in_tdata,   // [31:0] push_value
  input  wire logic                              in_tuser,   // [0] op
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [31:0] popped_value, [63:32] current_min, [95:64] current_max,
  // [102:96] depth_now, [103] is_empty, [105:104] status, rest zero
  output logic      [mms_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import mms_pkg::*;

  mms_cmd_t                  cmd;
  mms_sts_t                  sts;
  logic signed [WORD_W-1:0]  popped_value, current_min, current_max;
  logic [DEPTH_W-1:0]        depth_now;
  logic                      is_empty;
  logic [STS_W-1:0]          status;

  mms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mms_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_value   (in_tdata[WORD_W-1:0]),
    .cmd          (cmd),
    .sts          (sts),
    .popped_value (popped_value),
    .current_min  (current_min),
    .current_max  (current_max),
    .depth_now    (depth_now),
    .is_empty     (is_empty),
    .status       (status)
  );

  // Pack the result fields, lowest first.
  assign out_tdata = OUT_DATA_W'({status, is_empty, depth_now,
                                  current_max, current_min, popped_value});

endmodule
`default_nettype wire

@@ hdl/mms_checker.sv @@
// Port-level checker for the min/max stack and its bind to the top level.
`default_nettype none
module mms_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [mms_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mms_pkg::*;

  logic [WORD_W-1:0]  res_min, res_max;
  logic [DEPTH_W-1:0] res_depth;
  logic               res_empty;
  logic [STS_W-1:0]   res_status;

  assign res_min    = out_tdata[2*WORD_W-1:WORD_W];
  assign res_max    = out_tdata[3*WORD_W-1:2*WORD_W];
  assign res_depth  = out_tdata[3*WORD_W+DEPTH_W-1:3*WORD_W];
  assign res_empty  = out_tdata[3*WORD_W+DEPTH_W];
  assign res_status = out_tdata[3*WORD_W+DEPTH_W+STS_W:3*WORD_W+DEPTH_W+1];

  // A pending result stays offered until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before it was taken");

  // The empty flag agrees with the reported depth.
  a_empty_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_empty == (res_depth == '0)))
    else $error("empty flag and depth disagree");

  // An empty stack reports zero min and max.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_empty |-> (res_min == '0) && (res_max == '0))
    else $error("nonzero min or max on an empty stack");

  // A dropped push only happens at full depth; a pop error only on empty.
  a_err_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((res_status != ST_FULL) || (res_depth == DEPTH_W'(STACK_DEPTH)))
                && ((res_status != ST_EMPTY) || res_empty))
    else $error("error status does not match depth");

  // Min never exceeds max while entries remain.
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res_empty |-> ($signed(res_min) <= $signed(res_max)))
    else $error("minimum above maximum");

endmodule

bind min_max_stack mms_checker u_mms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the min/max stack: it mirrors the stack and checks every result.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mms_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 200;
  localparam int DRAIN_WAIT  = 10;

  // One expected result, field by field.
  typedef struct {
    logic [WORD_W-1:0]  popped;
    logic [WORD_W-1:0]  low_val;
    logic [WORD_W-1:0]  high_val;
    logic [DEPTH_W-1:0] depth;
    logic               empty;
    logic [STS_W-1:0]   status;
  } stack_report_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [31:0] push_value
  logic                  in_tuser;   // [0] op
  logic                  out_tvalid;
  logic                  out_tready;
  // [31:0] popped_value, [63:32] current_min, [95:64] current_max,
  // [102:96] depth_now, [103] is_empty, [105:104] status, rest zero
  logic [OUT_DATA_W-1:0] out_tdata;

  // Mirror of the stack contents, kept in step with accepted requests.
  logic [WORD_W-1:0] mirror_value [STACK_DEPTH];
  logic [WORD_W-1:0] mirror_min   [STACK_DEPTH];
  logic [WORD_W-1:0] mirror_max   [STACK_DEPTH];
  int                mirror_count;

  stack_report_t due_reports[$];
  int            error_count;
  bit            idle_on;
  int            hold_cycles;

  min_max_stack dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one accepted request to the mirror and queue the result it must produce.
  task automatic predict_stack_op(input logic op, input logic [WORD_W-1:0] val);
    stack_report_t     r;
    logic [WORD_W-1:0] nmin;
    logic [WORD_W-1:0] nmax;
    r.popped = '0;
    r.status = ST_OK;
    if (op == OP_PUSH) begin
      if (mirror_count >= STACK_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        nmin = val;
        nmax = val;
        if (mirror_count > 0) begin
          if ($signed(mirror_min[mirror_count-1]) <= $signed(val)) nmin = mirror_min[mirror_count-1];
          if ($signed(mirror_max[mirror_count-1]) >= $signed(val)) nmax = mirror_max[mirror_count-1];
        end
        mirror_value[mirror_count] = val;
        mirror_min[mirror_count]   = nmin;
        mirror_max[mirror_count]   = nmax;
        mirror_count++;
      end
    end else begin
      if (mirror_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        mirror_count--;
        r.popped = mirror_value[mirror_count];
      end
    end
    // An empty stack reports zero for both bounds.
    r.low_val  = (mirror_count > 0) ? mirror_min[mirror_count-1] : '0;
    r.high_val = (mirror_count > 0) ? mirror_max[mirror_count-1] : '0;
    r.depth    = DEPTH_W'(mirror_count);
    r.empty    = (mirror_count == 0);
    r.status   = r.status;
    due_reports.push_back(r);
  endtask

  // Values lean toward the extremes and small numbers so equal and crossing bounds occur.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1: return WORD_W'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Offer one request after a random gap and wait until the block takes it.
  task automatic send_request(input logic op, input logic [WORD_W-1:0] val);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= val;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_stack_op(op, val);
  endtask

  // Stop offering until every outstanding result has come back.
  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Check one delivered result against the oldest expectation.
  task automatic check_report(input logic [OUT_DATA_W-1:0] data);
    stack_report_t r;
    if (due_reports.size() == 0) begin
      $error("result arrived with no request outstanding: %h", data);
      error_count++;
    end else begin
      r = due_reports.pop_front();
      compare_field("popped_value", r.popped, data[31:0]);
      compare_field("current_min", r.low_val, data[63:32]);
      compare_field("current_max", r.high_val, data[95:64]);
      compare_field("depth_now", WORD_W'(r.depth), WORD_W'(data[102:96]));
      compare_field("is_empty", WORD_W'(r.empty), WORD_W'(data[103]));
      compare_field("status", WORD_W'(r.status), WORD_W'(data[105:104]));
    end
  endtask

  // Result side: random stalls, one long hold when asked, and a check per result.
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 5) : 0;
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      check_report(out_tdata);
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Extremes of the value, both operations, pops of an empty stack and equal values.
  task automatic test_directed();
    send_request(OP_POP, 32'hFFFF_FFFF);
    send_request(OP_PUSH, 32'h0000_0000);
    send_request(OP_PUSH, 32'h7FFF_FFFF);
    send_request(OP_PUSH, 32'h8000_0000);
    send_request(OP_PUSH, 32'hFFFF_FFFF);
    send_request(OP_PUSH, 32'h0000_0001);
    send_request(OP_PUSH, 32'h5555_5555);
    send_request(OP_PUSH, 32'hAAAA_AAAA);
    repeat (7) send_request(OP_POP, $urandom);
    send_request(OP_POP, 32'h0000_0000);
    send_request(OP_PUSH, 32'hFFFF_FFFB);
    send_request(OP_PUSH, 32'hFFFF_FFFB);
    send_request(OP_POP, 32'h8000_0000);
    send_request(OP_POP, 32'h7FFF_FFFF);
    send_request(OP_POP, 32'h1234_5678);
  endtask

  // Fill to capacity, push past it, then empty the stack completely.
  task automatic test_full_stack();
    while (mirror_count < STACK_DEPTH) send_request(OP_PUSH, pick_word());
    repeat (3) send_request(OP_PUSH, pick_word());
    send_request(OP_POP, $urandom);
    send_request(OP_PUSH, pick_word());
    send_request(OP_PUSH, pick_word());
    while (mirror_count > 0) send_request(OP_POP, $urandom);
    send_request(OP_POP, $urandom);
  endtask

  // Phases of random requests with different push bias so the depth wanders end to end.
  task automatic test_random_mix();
    int push_pct;
    for (int phase = 0; phase < 16; phase++) begin
      case (phase % 5)
        0: push_pct = 50;
        1: push_pct = 85;
        2: push_pct = 97;
        3: push_pct = 20;
        default: push_pct = 3;
      endcase
      idle_on = (phase % 4 != 3);
      for (int k = 0; k < 100; k++) begin
        send_request(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, pick_word());
      end
    end
    idle_on = 1'b1;
  endtask

  // Hold the result side for a long stretch while requests keep coming.
  task automatic test_output_hold();
    idle_on     = 1'b0;
    hold_cycles = LONG_HOLD;
    for (int k = 0; k < 40; k++) begin
      send_request(($urandom_range(0, 99) < 70) ? OP_PUSH : OP_POP, pick_word());
    end
    idle_on = 1'b1;
  endtask

  // Stop sending until the block has answered everything, then resume.
  task automatic test_drain_pause();
    for (int k = 0; k < 20; k++) send_request(1'($urandom_range(0, 1)), pick_word());
    pause_until_drained();
    for (int k = 0; k < 20; k++) send_request(1'($urandom_range(0, 1)), pick_word());
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= OP_PUSH;
    in_tdata    <= '0;
    mirror_count = 0;
    error_count  = 0;
    idle_on      = 1'b1;
    hold_cycles  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_stack();
    test_output_hold();
    test_random_mix();
    test_drain_pause();

    // Let every outstanding result arrive, then keep watching for strays.
    in_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
hdl/mms_pkg.sv
hdl/mms_ram.sv
hdl/mms_ctrl.sv
hdl/mms_dp.sv
hdl/min_max_stack.sv
hdl/mms_checker.sv
verif/tb.sv
